// File: src/rbc_pkg.sv
// Shared codes, widths and reset values for the reconnect backoff controller.
`timescale 1ns / 1ps
`default_nettype none
package rbc_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned ATT_W   = 8;
  localparam int unsigned TPS_W   = 10;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned CD_W    = TPS_W + DELAY_W;
  localparam int unsigned IDX_W   = 3;

  // Number of distinct backoff steps; later attempts reuse the last one.
  localparam int unsigned DELAY_STEPS = 5;
  localparam int unsigned DELAY_CAP   = (DELAY_STEPS - 1 > 4) ? 4 : DELAY_STEPS - 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRIGGER    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START_RES  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd5;

  // Link state codes
  localparam logic [STATE_W-1:0] LS_DISCONNECTED  = 3'd0;
  localparam logic [STATE_W-1:0] LS_CONNECTING    = 3'd1;
  localparam logic [STATE_W-1:0] LS_CONNECTED     = 3'd2;
  localparam logic [STATE_W-1:0] LS_DISCONNECTING = 3'd3;
  localparam logic [STATE_W-1:0] LS_RECONNECTING  = 3'd4;
  localparam logic [STATE_W-1:0] LS_ERROR         = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_TPS    = 3'd0;
  localparam logic [2:0] REG_DELAY0 = 3'd1;
  localparam logic [2:0] REG_DELAY1 = 3'd2;
  localparam logic [2:0] REG_DELAY2 = 3'd3;
  localparam logic [2:0] REG_DELAY3 = 3'd4;
  localparam logic [2:0] REG_DELAY4 = 3'd5;

  // Register reset values
  localparam logic [TPS_W-1:0]   TPS_RST    = 10'd1000;
  localparam logic [DELAY_W-1:0] DELAY0_RST = 8'd1;
  localparam logic [DELAY_W-1:0] DELAY1_RST = 8'd2;
  localparam logic [DELAY_W-1:0] DELAY2_RST = 8'd5;
  localparam logic [DELAY_W-1:0] DELAY3_RST = 8'd15;
  localparam logic [DELAY_W-1:0] DELAY4_RST = 8'd30;

  localparam logic [ATT_W-1:0] ATT_MAX = '1;

endpackage
`default_nettype wire

// File: src/reconnect_backoff_controller.sv
// Reconnect backoff controller: link retry state, backoff countdown and APB registers.
`timescale 1ns / 1ps
`default_nettype none
// One command item enters on the in_ channel and yields exactly one result item
// on the out_ channel carrying the link state, attempt count, armed flag and the
// request pulses it caused. An item is taken into an input register, processed in
// a single pass of combinational logic (one 8x10 multiply for the backoff load,
// a countdown decrement and the state update) and is written into the result
// register once the result slot is free; out_valid rises as it is written. The
// block accepts one item every cycle; in_ready only drops when the result register
// is full and out_ready is low while the input register also holds an item.
// Backoff registers (ticks_per_second and five per-step delays in seconds) are
// written over the APB port at byte address 4*i and should only be changed while
// no item is in flight.
module reconnect_backoff_controller
  import rbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   in_command,
  input  wire logic [STATE_W-1:0] in_reported_state,
  input  wire logic               in_start_ok,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [STATE_W-1:0]      out_link_state,
  output logic [ATT_W-1:0]        out_attempt_count,
  output logic                    out_retry_armed,
  output logic                    out_restart_request,
  output logic                    out_start_request,
  output logic                    out_stop_request,
  output logic                    out_error_report,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TPS_W-1:0]   tps_r;
  logic [DELAY_W-1:0] delay0_r, delay1_r, delay2_r, delay3_r, delay4_r;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= TPS_RST;
      delay0_r <= DELAY0_RST;
      delay1_r <= DELAY1_RST;
      delay2_r <= DELAY2_RST;
      delay3_r <= DELAY3_RST;
      delay4_r <= DELAY4_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_TPS:    tps_r    <= pwdata[TPS_W-1:0];
        REG_DELAY0: delay0_r <= pwdata[DELAY_W-1:0];
        REG_DELAY1: delay1_r <= pwdata[DELAY_W-1:0];
        REG_DELAY2: delay2_r <= pwdata[DELAY_W-1:0];
        REG_DELAY3: delay3_r <= pwdata[DELAY_W-1:0];
        REG_DELAY4: delay4_r <= pwdata[DELAY_W-1:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_TPS:    prdata = {{(32-TPS_W){1'b0}}, tps_r};
      REG_DELAY0: prdata = {{(32-DELAY_W){1'b0}}, delay0_r};
      REG_DELAY1: prdata = {{(32-DELAY_W){1'b0}}, delay1_r};
      REG_DELAY2: prdata = {{(32-DELAY_W){1'b0}}, delay2_r};
      REG_DELAY3: prdata = {{(32-DELAY_W){1'b0}}, delay3_r};
      REG_DELAY4: prdata = {{(32-DELAY_W){1'b0}}, delay4_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register in one pass
  // ---------------------------------------------------------------------------
  logic               in_valid_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [STATE_W-1:0] rep_r;
  logic               ok_r;
  logic               out_valid_r;
  logic               advance;
  logic               step_en;

  // Advance whenever the result slot is empty or being drained.
  assign advance  = ~out_valid_r | out_ready;
  assign in_ready = ~in_valid_r | advance;
  assign step_en  = advance & in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      cmd_r <= in_command;
      rep_r <= in_reported_state;
      ok_r  <= in_start_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] link_r, link_nxt;
  logic [ATT_W-1:0]   attempt_r, attempt_nxt;
  logic [CD_W-1:0]    countdown_r, countdown_nxt;
  logic               active_r, active_nxt;
  logic               user_stop_r, user_stop_nxt;
  logic               proto_r, proto_nxt;
  logic               from_retry_r, from_retry_nxt;
  logic               restart_nxt, start_nxt, stop_nxt, error_nxt;

  // Backoff load value: delay of the capped attempt index times ticks per second.
  // Every path that arms the timer sees the attempt count as it stood before
  // the item, so the register value selects the step.
  logic [IDX_W-1:0]   step_idx;
  logic [DELAY_W-1:0] delay_sel;
  logic [CD_W-1:0]    arm_value;
  logic [CD_W-1:0]    cd_dec;

  assign step_idx = (attempt_r >= ATT_W'(DELAY_CAP)) ? IDX_W'(DELAY_CAP)
                                                     : attempt_r[IDX_W-1:0];

  always_comb begin
    case (step_idx)
      3'd0:    delay_sel = delay0_r;
      3'd1:    delay_sel = delay1_r;
      3'd2:    delay_sel = delay2_r;
      3'd3:    delay_sel = delay3_r;
      default: delay_sel = delay4_r;
    endcase
  end

  assign arm_value = CD_W'(delay_sel) * CD_W'(tps_r);
  // Hold at zero: a zero countdown expires on the next tick.
  assign cd_dec    = (countdown_r != '0) ? countdown_r - CD_W'(1) : countdown_r;

  always_comb begin
    link_nxt       = link_r;
    attempt_nxt    = attempt_r;
    countdown_nxt  = countdown_r;
    active_nxt     = active_r;
    user_stop_nxt  = user_stop_r;
    proto_nxt      = proto_r;
    from_retry_nxt = from_retry_r;
    restart_nxt    = 1'b0;
    start_nxt      = 1'b0;
    stop_nxt       = 1'b0;
    error_nxt      = 1'b0;

    case (cmd_r)
      CMD_CONNECT: begin
        // Fresh connect: clear stop, cancel retry, create protocol.
        user_stop_nxt  = 1'b0;
        active_nxt     = 1'b0;
        countdown_nxt  = '0;
        attempt_nxt    = '0;
        link_nxt       = LS_CONNECTING;
        proto_nxt      = 1'b1;
        from_retry_nxt = 1'b0;
        start_nxt      = 1'b1;
      end
      CMD_DISCONNECT: begin
        user_stop_nxt = 1'b1;
        active_nxt    = 1'b0;
        countdown_nxt = '0;
        attempt_nxt   = '0;
        if (!proto_r) begin
          // A disconnected report never overrides reconnecting.
          if (link_r != LS_RECONNECTING) begin
            link_nxt = LS_DISCONNECTED;
          end
        end else begin
          link_nxt  = LS_DISCONNECTING;
          stop_nxt  = 1'b1;
          proto_nxt = 1'b0;
        end
      end
      CMD_REPORT: begin
        if (rep_r <= LS_ERROR &&
            !(rep_r == LS_DISCONNECTED && link_r == LS_RECONNECTING)) begin
          link_nxt = rep_r;
          if (rep_r == LS_CONNECTED) begin
            active_nxt    = 1'b0;
            countdown_nxt = '0;
            attempt_nxt   = '0;
          end else if (!user_stop_r &&
                       ((rep_r == LS_DISCONNECTED && link_r == LS_CONNECTED) ||
                        rep_r == LS_ERROR)) begin
            countdown_nxt = arm_value;
            active_nxt    = 1'b1;
          end
        end
      end
      CMD_TRIGGER: begin
        // Countdown keeps running if already armed.
        if (proto_r && link_r != LS_DISCONNECTING && link_r != LS_RECONNECTING &&
            !user_stop_r) begin
          if (attempt_r != ATT_MAX) begin
            attempt_nxt = attempt_r + ATT_W'(1);
          end
          link_nxt       = LS_RECONNECTING;
          restart_nxt    = 1'b1;
          from_retry_nxt = 1'b1;
        end
      end
      CMD_START_RES: begin
        if (proto_r && !ok_r) begin
          error_nxt = 1'b1;
          if (!from_retry_r) begin
            link_nxt = LS_ERROR;
          end
          if (!user_stop_r) begin
            countdown_nxt = arm_value;
            active_nxt    = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          countdown_nxt = cd_dec;
          if (cd_dec == '0) begin
            active_nxt = 1'b0;
            if (proto_r && link_r != LS_DISCONNECTING &&
                link_r != LS_RECONNECTING && !user_stop_r) begin
              if (attempt_r != ATT_MAX) begin
                attempt_nxt = attempt_r + ATT_W'(1);
              end
              link_nxt       = LS_RECONNECTING;
              restart_nxt    = 1'b1;
              from_retry_nxt = 1'b1;
            end
          end
        end
      end
      default: ;  // unknown command: report state, no pulses
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r       <= LS_DISCONNECTED;
      attempt_r    <= '0;
      countdown_r  <= '0;
      active_r     <= 1'b0;
      user_stop_r  <= 1'b0;
      proto_r      <= 1'b0;
      from_retry_r <= 1'b0;
    end else if (step_en) begin
      link_r       <= link_nxt;
      attempt_r    <= attempt_nxt;
      countdown_r  <= countdown_nxt;
      active_r     <= active_nxt;
      user_stop_r  <= user_stop_nxt;
      proto_r      <= proto_nxt;
      from_retry_r <= from_retry_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] res_link_r;
  logic [ATT_W-1:0]   res_attempt_r;
  logic               res_armed_r, res_restart_r, res_start_r, res_stop_r, res_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_link_r    <= link_nxt;
      res_attempt_r <= attempt_nxt;
      res_armed_r   <= active_nxt;
      res_restart_r <= restart_nxt;
      res_start_r   <= start_nxt;
      res_stop_r    <= stop_nxt;
      res_error_r   <= error_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_link_state      = res_link_r;
  assign out_attempt_count   = res_attempt_r;
  assign out_retry_armed     = res_armed_r;
  assign out_restart_request = res_restart_r;
  assign out_start_request   = res_start_r;
  assign out_stop_request    = res_stop_r;
  assign out_error_report    = res_error_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The timer is never armed while the user has stopped the link.
  a_armed_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !user_stop_r)
    else $error("backoff armed while user-stopped");

  // The attempt count only holds, steps up by one or returns to zero.
  a_attempt_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> (attempt_r == $past(attempt_r)) ||
                (attempt_r == $past(attempt_r) + ATT_W'(1)) || (attempt_r == '0))
    else $error("attempt count jumped");

  // A restart always counts an attempt and leaves the link reconnecting.
  a_restart_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_restart_request) |->
      (out_attempt_count != '0) && (out_link_state == LS_RECONNECTING))
    else $error("restart without attempt or reconnecting state");

  // A fresh connect leaves no retry armed and a cleared count.
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_request) |->
      !out_retry_armed && (out_attempt_count == '0) &&
      (out_link_state == LS_CONNECTING))
    else $error("connect left retry state behind");

endmodule
`default_nettype wire
